>>> rtl/core/ttrk_pkg.sv
package ttrk_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam logic [15:0] SCAN_RESET = 16'd200;

   localparam logic [1:0] KIND_QUERY  = 2'd0;
   localparam logic [1:0] KIND_REPLY  = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_CANCEL = 2'd3;

   localparam logic [2:0] RES_ISSUED    = 3'd0;
   localparam logic [2:0] RES_RESPONSE  = 3'd1;
   localparam logic [2:0] RES_ERROR     = 3'd2;
   localparam logic [2:0] RES_TIMEOUT   = 3'd3;
   localparam logic [2:0] RES_UNMATCHED = 3'd4;
   localparam logic [2:0] RES_FULL      = 3'd5;

   localparam logic REG_SCAN  = 1'b0;
   localparam logic REG_START = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [15:0] tid;
      logic [31:0] addr;
      logic [15:0] port;
      logic [31:0] sent;
      logic [31:0] deadline;
   } slot_type;

   // Commands to a cell: clear drops every slot, write loads the tail cell
   typedef struct packed {
      logic        clear_all;
      logic        write_en;
   } cell_ctl_type;

endpackage

>>> rtl/core/ttrk_if.sv
interface ttrk_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] peer_addr;
   logic [15:0] peer_port;
   logic [15:0] timeout_ms;
   logic [15:0] reply_tid;
   logic        reply_is_error;
   modport source (output valid, kind, peer_addr, peer_port, timeout_ms, reply_tid,
                   reply_is_error, input ready);
   modport sink (input valid, kind, peer_addr, peer_port, timeout_ms, reply_tid,
                 reply_is_error, output ready);
endinterface

interface ttrk_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [15:0] out_tid;
   logic [31:0] out_addr;
   logic [15:0] out_port;
   logic [15:0] rtt_ms;
   logic        last;
   modport source (output valid, result_kind, out_tid, out_addr, out_port, rtt_ms, last,
                   input ready);
   modport sink (input valid, result_kind, out_tid, out_addr, out_port, rtt_ms, last,
                 output ready);
endinterface

>>> rtl/core/ttrk_cell.sv
// One table slot. The ring rotates by one slot each cycle when shift is set;
// a full rotation of ENTRIES shifts returns every slot to its place.
module ttrk_cell
   import ttrk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         shift,
   input  cell_ctl_type ctl,
   input  slot_type     wr_slot,
   input  logic         kill,
   input  slot_type     prev_slot,
   output slot_type     slot
);

   slot_type slot_ff, slot_in;

   // Rotate, write or drop the held slot
   always_comb begin
      slot_in = slot_ff;
      if (shift) slot_in = prev_slot;
      if (kill) slot_in.valid = 1'b0;
      if (ctl.write_en) slot_in = wr_slot;
      if (ctl.clear_all) slot_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.tid      <= slot_in.tid;
      slot_ff.addr     <= slot_in.addr;
      slot_ff.port     <= slot_in.port;
      slot_ff.sent     <= slot_in.sent;
      slot_ff.deadline <= slot_in.deadline;
   end

   assign slot = slot_ff;

endmodule

>>> rtl/core/transaction_tracker_with_timeout.sv
// Channel   Dir  Payload
// req       in   kind, peer_addr, peer_port, timeout_ms, reply_tid, reply_is_error
// rsp       out  result_kind, out_tid, out_addr, out_port, rtt_ms, last
// csr       in   csr_we, csr_index, csr_wdata (16 bit)
//
// Slots sit in a ring of ENTRIES cells rotating toward cell 0; the head is inspected
// each cycle and dropped or replaced as it wraps to the tail. Accepting registers the request.
// A query rotates once for a free slot (a full table stops there), once per id
// candidate (1 to ENTRIES+1) and once to place the slot: 3 to ENTRIES+3 rotations.
// A reply or scanning tick takes one rotation; cancel and other ticks nothing more.
// Reset is synchronous and empties the table. A held result blocks new requests; the
// scan stalls while its result is held and releases its last timeout in a flush step.
module transaction_tracker_with_timeout
   import ttrk_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ttrk_req_if.sink    req,
   ttrk_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FREE  = 3'd1;
   localparam logic [2:0] ST_IDSCN = 3'd2;
   localparam logic [2:0] ST_REPLY = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_PLACE = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;
   localparam logic [2:0] ST_FLUSH = 3'd7;

   slot_type slots [ENTRIES];
   slot_type head, wr_slot;
   cell_ctl_type ctl;
   logic shift, kill_head, stall;

   logic [2:0]  st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in, tries_ff, tries_in;
   logic [IW-1:0] free_ff, free_in, place_ff, place_in;
   logic          have_free_ff, have_free_in, hit_ff, hit_in, done_ff, done_in;
   logic [15:0] scan_ff, idc_ff, idc_in, cand_ff, cand_in, cd_ff, cd_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] addr_ff;
   logic [15:0] port_ff, tmo_ff, rtid_ff;
   logic        err_ff;
   logic        ov_ff, ov_in, last_pend_ff, last_pend_in;
   logic [15:0] ptid_ff, ptid_in, pport_ff, pport_in;
   logic [31:0] paddr_ff, paddr_in;
   logic [2:0]  ok_ff, ok_in;
   logic [15:0] otid_ff, otid_in, ortt_ff, ortt_in, oport_ff, oport_in;
   logic [31:0] oaddr_ff, oaddr_in, rtt_full;
   logic        olast_ff, olast_in;

   // Build the ring; the tail cell takes the head as it wraps
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      cell_ctl_type cell_ctl;
      assign cell_ctl = {ctl.clear_all, ctl.write_en && (g == ENTRIES - 1)};
      ttrk_cell u_cell (
         .clock, .reset, .shift,
         .ctl     (cell_ctl),
         .wr_slot (wr_slot),
         .kill    (kill_head && (g == ENTRIES - 1)),
         .prev_slot (slots[(g + 1) % ENTRIES]),
         .slot    (slots[g])
      );
   end

   function automatic logic now_ff_sub_msb(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   assign head  = slots[0];
   assign stall = ov_ff && !rsp.ready;
   assign req.ready = (st_ff == ST_IDLE) && !ov_ff;
   assign rtt_full = now_ff - head.sent;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; tries_in = tries_ff;
      free_in = free_ff; have_free_in = have_free_ff; place_in = place_ff;
      hit_in = hit_ff; done_in = done_ff;
      idc_in = idc_ff; cand_in = cand_ff; cd_in = cd_ff; now_in = now_ff;
      ov_in = ov_ff && !rsp.ready; last_pend_in = last_pend_ff;
      ptid_in = ptid_ff; paddr_in = paddr_ff; pport_in = pport_ff;
      ok_in = ok_ff; otid_in = otid_ff; oaddr_in = oaddr_ff; oport_in = oport_ff;
      ortt_in = ortt_ff; olast_in = olast_ff;
      shift = 1'b0; kill_head = 1'b0;
      ctl = '0;
      wr_slot.valid = 1'b1; wr_slot.tid = cand_ff; wr_slot.addr = addr_ff;
      wr_slot.port = port_ff; wr_slot.sent = now_ff;
      wr_slot.deadline = now_ff + {16'd0, tmo_ff};

      case (st_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cnt_in = '0; have_free_in = 1'b0; free_in = '0;
               hit_in = 1'b0; done_in = 1'b0; last_pend_in = 1'b0;
               case (req.kind)
                  KIND_QUERY: st_in = ST_FREE;
                  KIND_REPLY: st_in = ST_REPLY;
                  KIND_TICK: begin
                     now_in = now_ff + 32'd1;
                     if (cd_ff != 16'd0) begin
                        cd_in = cd_ff - 16'd1;
                     end else begin
                        cd_in = (scan_ff != 16'd0) ? scan_ff - 16'd1 : 16'd0;
                        st_in = ST_SCAN;
                     end
                  end
                  default: ctl.clear_all = 1'b1;
               endcase
            end
         end
         // Find lowest free slot
         ST_FREE: begin
            shift = 1'b1;
            if (!head.valid && !have_free_ff) begin
               have_free_in = 1'b1; free_in = cnt_ff[IW-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               cnt_in = '0;
               if (!have_free_in) begin
                  ok_in = RES_FULL; otid_in = idc_ff; oaddr_in = addr_ff;
                  oport_in = port_ff; ortt_in = '0; olast_in = 1'b1;
                  ov_in = 1'b1; st_in = ST_IDLE;
               end else begin
                  cand_in = idc_ff; tries_in = '0; hit_in = 1'b0; st_in = ST_IDSCN;
               end
            end
         end
         // Check one candidate id per rotation
         ST_IDSCN: begin
            shift = 1'b1;
            hit_in = hit_ff || (head.valid && head.tid == cand_ff);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               cnt_in = '0; hit_in = 1'b0;
               if (hit_ff || (head.valid && head.tid == cand_ff)) begin
                  cand_in = cand_ff + 16'd1;
                  if (tries_ff == CW'(ENTRIES)) st_in = ST_PLACE;
                  tries_in = tries_ff + 1'b1;
               end else begin
                  st_in = ST_PLACE;
               end
               place_in = free_ff;
            end
         end
         // Rotate target slot to head; ST_OUT then writes it
         ST_PLACE: begin
            if (place_ff == '0) begin
               ctl.write_en = 1'b0;
               idc_in = cand_ff + 16'd1;
               ok_in = RES_ISSUED; otid_in = cand_ff; oaddr_in = addr_ff;
               oport_in = port_ff; ortt_in = '0; olast_in = 1'b1;
               ov_in = 1'b1; st_in = ST_OUT; cnt_in = '0;
            end else begin
               shift = 1'b1; place_in = place_ff - 1'b1; cnt_in = cnt_ff + 1'b1;
            end
         end
         // Replace the head slot as it wraps to the tail, then finish the rotation
         ST_OUT: begin
            if (!done_ff) begin
               done_in = 1'b1;
            end
            shift = 1'b1; cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ENTRIES - 1) - CW'(free_ff)) begin
               st_in = ST_IDLE; cnt_in = '0;
            end
         end
         // Match reply
         ST_REPLY: begin
            shift = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (!done_ff && head.valid && head.tid == rtid_ff) begin
               done_in = 1'b1;
               if (head.addr == addr_ff && head.port == port_ff) begin
                  hit_in = 1'b1; kill_head = 1'b1;
                  ok_in = err_ff ? RES_ERROR : RES_RESPONSE;
                  ortt_in = (rtt_full > 32'h0000_ffff) ? 16'hffff : rtt_full[15:0];
               end
            end
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               cnt_in = '0;
               if (!hit_in) begin ok_in = RES_UNMATCHED; ortt_in = '0; end
               otid_in = rtid_ff; oaddr_in = addr_ff; oport_in = port_ff;
               olast_in = 1'b1; ov_in = 1'b1; st_in = ST_IDLE;
            end
         end
         // Expiry scan: hold one timeout back so the final one can carry last
         ST_SCAN: begin
            if (!stall) begin
               shift = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (head.valid && !now_ff_sub_msb(now_ff, head.deadline)) begin
                  kill_head = 1'b1;
                  if (last_pend_ff) begin
                     ok_in = RES_TIMEOUT; otid_in = ptid_ff; oaddr_in = paddr_ff;
                     oport_in = pport_ff; ortt_in = '0; olast_in = 1'b0; ov_in = 1'b1;
                  end
                  ptid_in = head.tid; paddr_in = head.addr; pport_in = head.port;
                  last_pend_in = 1'b1;
               end
               if (cnt_ff == CW'(ENTRIES - 1)) begin
                  cnt_in = '0;
                  st_in = last_pend_in ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         // Release the held timeout as the final result
         ST_FLUSH: begin
            if (!stall) begin
               ok_in = RES_TIMEOUT; otid_in = ptid_ff; oaddr_in = paddr_ff;
               oport_in = pport_ff; ortt_in = '0; olast_in = 1'b1; ov_in = 1'b1;
               last_pend_in = 1'b0; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_OUT && !done_ff) ctl.write_en = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0; cnt_ff <= '0; tries_ff <= '0;
         scan_ff <= SCAN_RESET; idc_ff <= '0;
         now_ff <= '0; cd_ff <= '0; have_free_ff <= 1'b0; hit_ff <= 1'b0;
         done_ff <= 1'b0; last_pend_ff <= 1'b0; free_ff <= '0; place_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; cnt_ff <= cnt_in; tries_ff <= tries_in;
         now_ff <= now_in; cd_ff <= cd_in; have_free_ff <= have_free_in;
         hit_ff <= hit_in; done_ff <= done_in; last_pend_ff <= last_pend_in;
         free_ff <= free_in; place_ff <= place_in;
         if (csr_we && csr_index == REG_SCAN) scan_ff <= csr_wdata;
         if (csr_we && csr_index == REG_START) idc_ff <= csr_wdata;
         else idc_ff <= idc_in;
      end
      cand_ff <= cand_in;
      ptid_ff <= ptid_in; paddr_ff <= paddr_in; pport_ff <= pport_in;
      ok_ff <= ok_in; otid_ff <= otid_in; oaddr_ff <= oaddr_in;
      oport_ff <= oport_in; ortt_ff <= ortt_in; olast_ff <= olast_in;
      if (req.valid && req.ready) begin
         addr_ff <= req.peer_addr; port_ff <= req.peer_port;
         tmo_ff <= req.timeout_ms; rtid_ff <= req.reply_tid; err_ff <= req.reply_is_error;
      end
   end

   assign rsp.valid       = ov_ff;
   assign rsp.result_kind = ok_ff;
   assign rsp.out_tid     = otid_ff;
   assign rsp.out_addr    = oaddr_ff;
   assign rsp.out_port    = oport_ff;
   assign rsp.rtt_ms      = ortt_ff;
   assign rsp.last        = olast_ff;

endmodule
